// ===== hw/rtl/gal_pkg.sv =====
package gal_pkg;

  // Code table geometry
  localparam int TABLE_DEPTH = 256;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = IDX_W + 1;

  // Field and register widths
  localparam int CODE_W  = 21;
  localparam int SLOT_W  = 8;
  localparam int GIDX_W  = 8;
  localparam int COORD_W = 20;
  localparam int REG_W   = 12;
  localparam int ECNT_W  = 9;
  localparam int DATA_W  = 32;
  localparam int ADDR_W  = 4;

  // Divider compare width covers both the partial remainder and the divisor
  localparam int CMP_W   = (IDX_W + 1 > REG_W) ? IDX_W + 1 : REG_W;
  localparam int STEP_W  = (IDX_W > 1) ? $clog2(IDX_W) : 1;
  localparam int PROD_W  = IDX_W + REG_W;

  // Register indexes (word address)
  localparam logic [1:0] REG_ROW_SIZE    = 2'd0;
  localparam logic [1:0] REG_CELL_WIDTH  = 2'd1;
  localparam logic [1:0] REG_CELL_HEIGHT = 2'd2;
  localparam logic [1:0] REG_ENTRY_COUNT = 2'd3;

  // Request function codes
  localparam logic FUNC_LOAD   = 1'b0;
  localparam logic FUNC_LOOKUP = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_CHECK,
    ST_DIV,
    ST_DONE
  } gal_state_e;

  // Quotient and remainder from the divider
  typedef struct packed {
    logic [IDX_W-1:0] quo;
    logic [IDX_W-1:0] rem;
  } div_res_t;

endpackage

// ===== hw/rtl/glyph_atlas_lookup_unit.sv =====
// Glyph atlas lookup: binary search of a sorted code table, then cell coordinates.
// Load request: written to the table RAM, no result.
// Lookup request: up to 9 search probes (one table RAM read each), one match check,
// a restoring division of the index by the row size, then the output register.
// Input stalls until the result is in the output register; one request in flight.
// Reset: registers return to 32/64/64/0; the code table RAM is not cleared.
module glyph_atlas_lookup_unit
  import gal_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  // request channel
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               func_i,
  input  logic [SLOT_W-1:0]  slot_i,
  input  logic [CODE_W-1:0]  code_i,
  // result channel
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               found_o,
  output logic [GIDX_W-1:0]  glyph_index_o,
  output logic [COORD_W-1:0] atlas_x_o,
  output logic [COORD_W-1:0] atlas_y_o,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready
);

  // Configuration registers
  logic [REG_W-1:0]  row_size_q, cell_width_q, cell_height_q;
  logic [ECNT_W-1:0] entry_count_q;
  logic              cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_size_q    <= REG_W'(32);
      cell_width_q  <= REG_W'(64);
      cell_height_q <= REG_W'(64);
      entry_count_q <= '0;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_ROW_SIZE:    row_size_q    <= pwdata[REG_W-1:0];
        REG_CELL_WIDTH:  cell_width_q  <= pwdata[REG_W-1:0];
        REG_CELL_HEIGHT: cell_height_q <= pwdata[REG_W-1:0];
        REG_ENTRY_COUNT: entry_count_q <= pwdata[ECNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_ROW_SIZE:    prdata = DATA_W'(row_size_q);
      REG_CELL_WIDTH:  prdata = DATA_W'(cell_width_q);
      REG_CELL_HEIGHT: prdata = DATA_W'(cell_height_q);
      REG_ENTRY_COUNT: prdata = DATA_W'(entry_count_q);
      default:         prdata = '0;
    endcase
  end

  // Search state
  gal_state_e        state_q, state_d;
  logic [CNT_W-1:0]  lo_q, lo_d;
  logic [CNT_W-1:0]  len_q, len_d;
  logic [CNT_W-1:0]  n_q, n_d;
  logic              pend_q, pend_d;
  logic              hit_q, hit_d;
  logic [CODE_W-1:0] key_q, key_d;

  // Output register
  logic               out_valid_q, out_valid_d;
  logic               found_q, found_d;
  logic [GIDX_W-1:0]  gidx_q, gidx_d;
  logic [COORD_W-1:0] ax_q, ax_d;
  logic [COORD_W-1:0] ay_q, ay_d;

  // Table RAM and divider hookup
  logic              ram_we;
  logic [IDX_W-1:0]  ram_addr;
  logic [CODE_W-1:0] ram_rdata;
  logic              div_start;
  logic              div_done;
  div_res_t          div_res;
  logic [REG_W-1:0]  rs_eff;

  // Probe update temporaries
  logic [CNT_W-1:0]  half;
  logic [CNT_W-1:0]  mid;
  logic [CNT_W-1:0]  lo_n, len_n;
  logic [CNT_W-1:0]  n_sat;
  logic              accept;
  logic              out_free;
  logic [PROD_W-1:0] prod_x, prod_y;

  assign accept   = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE);
  assign out_free = !(out_valid_q && out_stall_i);
  assign rs_eff   = (row_size_q == '0) ? REG_W'(1) : row_size_q;
  assign n_sat    = (entry_count_q > ECNT_W'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH)
                                                           : CNT_W'(entry_count_q);

  // Cell coordinates from quotient and remainder
  assign prod_x = PROD_W'(div_res.rem) * PROD_W'(cell_width_q);
  assign prod_y = PROD_W'(div_res.quo) * PROD_W'(cell_height_q);

  always_comb begin
    state_d     = state_q;
    lo_d        = lo_q;
    len_d       = len_q;
    n_d         = n_q;
    pend_d      = pend_q;
    hit_d       = hit_q;
    key_d       = key_q;
    out_valid_d = out_valid_q && out_stall_i;
    found_d     = found_q;
    gidx_d      = gidx_q;
    ax_d        = ax_q;
    ay_d        = ay_q;
    ram_we      = 1'b0;
    ram_addr    = IDX_W'(slot_i);
    div_start   = 1'b0;
    half        = len_q >> 1;
    mid         = lo_q + half;
    lo_n        = lo_q;
    len_n       = len_q;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (func_i == FUNC_LOAD) begin
            ram_we = ({{(32-SLOT_W){1'b0}}, slot_i} < TABLE_DEPTH);
          end else begin
            lo_d    = '0;
            len_d   = n_sat;
            n_d     = n_sat;
            pend_d  = 1'b0;
            key_d   = code_i;
            state_d = ST_SEARCH;
          end
        end
      end

      // One probe per cycle: fold in last read, issue the next
      ST_SEARCH: begin
        if (pend_q) begin
          if (ram_rdata < key_q) begin
            lo_n  = mid + CNT_W'(1);
            len_n = len_q - half - CNT_W'(1);
          end else begin
            len_n = half;
          end
        end
        lo_d  = lo_n;
        len_d = len_n;
        if (len_n != '0) begin
          ram_addr = IDX_W'(lo_n + (len_n >> 1));
          pend_d   = 1'b1;
        end else begin
          pend_d = 1'b0;
          if (lo_n < n_q) begin
            ram_addr = IDX_W'(lo_n);
            state_d  = ST_CHECK;
          end else begin
            hit_d   = 1'b0;
            state_d = ST_DONE;
          end
        end
      end

      // Exact match test on the lower bound entry
      ST_CHECK: begin
        ram_addr = IDX_W'(lo_q);
        if (ram_rdata == key_q) begin
          hit_d     = 1'b1;
          div_start = 1'b1;
          state_d   = ST_DIV;
        end else begin
          hit_d   = 1'b0;
          state_d = ST_DONE;
        end
      end

      ST_DIV: begin
        ram_addr = IDX_W'(lo_q);
        if (div_done) begin
          state_d = ST_DONE;
        end
      end

      // Multiply into the output register once it is free
      ST_DONE: begin
        ram_addr = IDX_W'(lo_q);
        if (out_free) begin
          out_valid_d = 1'b1;
          found_d     = hit_q;
          gidx_d      = hit_q ? GIDX_W'(lo_q) : '0;
          ax_d        = hit_q ? COORD_W'(prod_x) : '0;
          ay_d        = hit_q ? COORD_W'(prod_y) : '0;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q    <= lo_d;
    len_q   <= len_d;
    n_q     <= n_d;
    hit_q   <= hit_d;
    key_q   <= key_d;
    found_q <= found_d;
    gidx_q  <= gidx_d;
    ax_q    <= ax_d;
    ay_q    <= ay_d;
  end

  gal_ram #(
    .WIDTH (CODE_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (code_i),
    .rdata_o (ram_rdata)
  );

  gal_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (IDX_W'(lo_q)),
    .divisor_i  (rs_eff),
    .done_o     (div_done),
    .res_o      (div_res)
  );

  assign out_valid_o   = out_valid_q;
  assign found_o       = found_q;
  assign glyph_index_o = gidx_q;
  assign atlas_x_o     = ax_q;
  assign atlas_y_o     = ay_q;

endmodule

// ===== hw/rtl/gal_ram.sv =====
module gal_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Single port, registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/gal_div.sv =====
module gal_div
  import gal_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [IDX_W-1:0] dividend_i,
  input  logic [REG_W-1:0] divisor_i,
  output logic             done_o,
  output div_res_t         res_o
);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [STEP_W-1:0] cnt_q, cnt_d;
  logic [IDX_W-1:0]  dvd_q, dvd_d;
  logic [IDX_W-1:0]  rem_q, rem_d;
  logic [REG_W-1:0]  dvs_q, dvs_d;
  logic [CMP_W-1:0]  shifted;
  logic [CMP_W-1:0]  diff;
  logic              ge;

  // One restoring step per cycle, quotient bits shift into the dividend
  always_comb begin
    shifted = CMP_W'({rem_q, dvd_q[IDX_W-1]});
    diff    = shifted - CMP_W'(dvs_q);
    ge      = shifted >= CMP_W'(dvs_q);
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    dvd_d   = dvd_q;
    rem_d   = rem_q;
    dvs_d   = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = STEP_W'(IDX_W - 1);
      dvd_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = ge ? IDX_W'(diff) : IDX_W'(shifted);
      dvd_d = {dvd_q[IDX_W-2:0], ge};
      cnt_d = cnt_q - STEP_W'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o  = done_q;
  assign res_o.quo = dvd_q;
  assign res_o.rem = rem_q;

endmodule
